// ----- src/tpbp_pkg.sv -----
// shared constants, op codes and helper functions of the test pattern bit packer
package tpbp_pkg;

    localparam int NUM_VARS_DEF = 1024;
    localparam int NUM_COLS_DEF = 64;
    localparam int MAX_LITS_DEF = 64;

    localparam int OP_W      = 2;
    localparam int VAR_IDX_W = 10;
    localparam int COL_W     = 6;
    localparam int CFG_W     = 7;
    localparam int WORD_W    = 64;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LIT   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // column count limited to the range 2 .. ncols
    function automatic logic [CFG_W-1:0] clamp_cols(input logic [CFG_W-1:0] c,
                                                    input int ncols);
        logic [CFG_W-1:0] r;
        r = c;
        if (r < 7'd2)
            r = 7'd2;
        if (r > CFG_W'(ncols))
            r = CFG_W'(ncols);
        return r;
    endfunction

    // variable index modulo the store depth, by conditional subtraction of
    // shifted copies of the depth (all shifted values are constants)
    function automatic logic [VAR_IDX_W-1:0] var_reduce(input logic [VAR_IDX_W-1:0] v,
                                                        input int nvars);
        int r;
        r = int'(v);
        if (nvars < (1 << VAR_IDX_W)) begin
            for (int s = VAR_IDX_W - 1; s >= 0; s--) begin
                if ((nvars << s) < (1 << VAR_IDX_W) && r >= (nvars << s))
                    r = r - (nvars << s);
            end
        end
        return VAR_IDX_W'(r);
    endfunction

endpackage

// ----- src/tpbp_if.sv -----
// request and result channel interfaces of the test pattern bit packer
interface tpbp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [9:0] var_index;
    logic       negated;
    logic       last_literal;

    modport source(output valid, output op, output var_index, output negated,
                   output last_literal, input ready);
    modport sink(input valid, input op, input var_index, input negated,
                 input last_literal, output ready);
endinterface

interface tpbp_out_if;
    logic        valid;
    logic        ready;
    logic        placed;
    logic [5:0]  column;
    logic        batch_full;
    logic        dropped;
    logic [63:0] read_value;
    logic [63:0] read_present;

    modport source(output valid, output placed, output column, output batch_full,
                   output dropped, output read_value, output read_present, input ready);
    modport sink(input valid, input placed, input column, input batch_full,
                 input dropped, input read_value, input read_present, output ready);
endinterface

// ----- src/tpbp_ram.sv -----
// generic simple dual port ram, one write and one registered read per cycle
module tpbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we)
            mem[i_waddr] <= i_wdata;
        if (i_re)
            r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/test_pattern_bit_packer_top.sv -----
// top level of the test pattern bit packer
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    op, var_index, negated, last_literal
//  o_out     out  valid/ready    placed, column, batch_full, dropped, read_value, read_present
//  i_cfg     in   write enable   columns_in_use
//
//  a literal that does not end its pattern does a store read, then a conflict merge
//  a last literal that is placed walks the buffered pattern: each buffered
//  literal is one read and one write of the single store ram port pair
//  clear op and reset both sweep the store, with i_in.ready low
//  read op does a registered store read; a result waiting on o_out holds the finishing state
module test_pattern_bit_packer_top #(
    parameter int NUM_VARS = tpbp_pkg::NUM_VARS_DEF,
    parameter int NUM_COLS = tpbp_pkg::NUM_COLS_DEF,
    parameter int MAX_LITS = tpbp_pkg::MAX_LITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tpbp_in_if.sink                    i_in,
    tpbp_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [tpbp_pkg::CFG_W-1:0] i_cfg_wdata
);
    import tpbp_pkg::*;

    localparam int VAR_AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int BUF_AW = (MAX_LITS > 1) ? $clog2(MAX_LITS) : 1;
    localparam int LEN_W  = $clog2(MAX_LITS + 1);
    localparam int BUF_W  = VAR_AW + 1;
    localparam int ST_W   = 2 * NUM_COLS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LIT,
        ST_PICK,
        ST_WADDR,
        ST_WWR,
        ST_READ,
        ST_EMIT
    } t_state;

    t_state               r_state;
    logic [VAR_AW-1:0]    r_sweep_addr;
    logic                 r_clr_emit;
    logic [CFG_W-1:0]     r_cols;
    logic                 r_full;
    logic [LEN_W-1:0]     r_len;
    logic [NUM_COLS-1:0]  r_conflict;
    logic                 r_last;
    logic                 r_neg;
    logic [VAR_AW-1:0]    r_var;
    logic [COL_W-1:0]     r_col;
    logic [LEN_W-1:0]     r_walk;
    logic                 r_emit_placed;

    logic                 r_out_valid;
    logic                 r_o_placed;
    logic [COL_W-1:0]     r_o_column;
    logic                 r_o_full;
    logic                 r_o_dropped;
    logic [WORD_W-1:0]    r_o_value;
    logic [WORD_W-1:0]    r_o_present;

    // ram ports
    logic                 store_we, store_re;
    logic [VAR_AW-1:0]    store_waddr, store_raddr;
    logic [ST_W-1:0]      store_wdata, store_rdata;
    logic                 buf_we, buf_re;
    logic [BUF_AW-1:0]    buf_waddr, buf_raddr;
    logic [BUF_W-1:0]     buf_wdata, buf_rdata;

    logic                 accept;
    logic                 slot_free;
    logic                 out_load;
    logic [VAR_AW-1:0]    in_var;
    logic [CFG_W-1:0]     cols_eff;
    logic [NUM_COLS-1:0]  st_val, st_pres;
    logic [NUM_COLS-1:0]  conflict_nxt;
    logic [NUM_COLS-1:0]  col_mask;
    logic [NUM_COLS-1:0]  avail;
    logic                 col_found;
    logic [COL_W-1:0]     col_pick;
    logic [NUM_COLS-1:0]  col_bit;
    logic [LEN_W-1:0]     walk_nxt;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign slot_free  = !r_out_valid || o_out.ready;
    assign in_var     = VAR_AW'(var_reduce(i_in.var_index, NUM_VARS));
    assign cols_eff   = clamp_cols(r_cols, NUM_COLS);

    // result register reloaded this cycle
    assign out_load = slot_free && (((r_state == ST_LIT) && !r_last) ||
                                    ((r_state == ST_PICK) && !(!r_full && col_found)) ||
                                    (r_state == ST_READ) || (r_state == ST_EMIT));

    assign st_val       = store_rdata[NUM_COLS-1:0];
    assign st_pres      = store_rdata[ST_W-1:NUM_COLS];
    assign conflict_nxt = r_conflict | (st_pres & (r_neg ? st_val : ~st_val));
    assign col_bit      = NUM_COLS'(1) << r_col;
    assign walk_nxt     = r_walk + LEN_W'(1);

    // usable columns exclude the reserved column zero
    always_comb begin
        for (int j = 0; j < NUM_COLS; j++)
            col_mask[j] = (j >= 1) && (CFG_W'(j) < cols_eff);
    end

    assign avail = ~r_conflict & col_mask;

    // lowest free column
    always_comb begin
        col_found = 1'b0;
        col_pick  = '0;
        for (int j = NUM_COLS - 1; j >= 1; j--) begin
            if (avail[j]) begin
                col_found = 1'b1;
                col_pick  = COL_W'(j);
            end
        end
    end

    always_comb begin
        store_we    = 1'b0;
        store_waddr = r_var;
        store_wdata = {st_pres | col_bit, r_neg ? (st_val & ~col_bit) : (st_val | col_bit)};
        store_re    = 1'b0;
        store_raddr = in_var;
        buf_we      = 1'b0;
        buf_waddr   = r_len[BUF_AW-1:0];
        buf_wdata   = {i_in.negated, in_var};
        buf_re      = 1'b0;
        buf_raddr   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                store_we    = 1'b1;
                store_waddr = r_sweep_addr;
                store_wdata = '0;
            end
            ST_IDLE: begin
                if (accept && (i_in.op == OP_LIT || i_in.op == OP_READ))
                    store_re = (i_in.op == OP_READ) || (r_len < LEN_W'(MAX_LITS));
                if (accept && i_in.op == OP_LIT && r_len < LEN_W'(MAX_LITS))
                    buf_we = 1'b1;
            end
            ST_PICK: begin
                buf_re = 1'b1;
            end
            ST_WADDR: begin
                store_re    = 1'b1;
                store_raddr = buf_rdata[VAR_AW-1:0];
                buf_re      = 1'b1;
                buf_raddr   = walk_nxt[BUF_AW-1:0];
            end
            ST_WWR: begin
                store_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_sweep_addr  <= '0;
            r_clr_emit    <= 1'b0;
            r_cols        <= CFG_RESET;
            r_full        <= 1'b0;
            r_len         <= '0;
            r_conflict    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_cols <= i_cfg_wdata;
            if (r_out_valid && o_out.ready && !out_load)
                r_out_valid <= 1'b0;

            unique case (r_state)
                ST_CLEAR: begin
                    r_sweep_addr <= r_sweep_addr + VAR_AW'(1);
                    if (r_sweep_addr == VAR_AW'(NUM_VARS - 1)) begin
                        r_emit_placed <= 1'b0;
                        r_state       <= r_clr_emit ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_neg  <= i_in.negated;
                        r_last <= i_in.last_literal;
                        case (i_in.op)
                            OP_CLEAR: begin
                                r_full       <= 1'b0;
                                r_len        <= '0;
                                r_conflict   <= '0;
                                r_sweep_addr <= '0;
                                r_clr_emit   <= 1'b1;
                                r_state      <= ST_CLEAR;
                            end
                            OP_LIT: begin
                                r_emit_placed <= 1'b0;
                                if (r_len < LEN_W'(MAX_LITS)) begin
                                    r_len   <= r_len + LEN_W'(1);
                                    r_state <= ST_LIT;
                                end else begin
                                    // literal past the buffer depth is ignored
                                    r_state <= i_in.last_literal ? ST_PICK : ST_EMIT;
                                end
                            end
                            OP_READ: begin
                                r_state <= ST_READ;
                            end
                            default: begin
                                r_emit_placed <= 1'b0;
                                r_state       <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_LIT: begin
                    if (r_last) begin
                        r_conflict <= conflict_nxt;
                        r_state    <= ST_PICK;
                    end else if (slot_free) begin
                        r_conflict  <= conflict_nxt;
                        r_out_valid <= 1'b1;
                        r_o_placed  <= 1'b0;
                        r_o_column  <= '0;
                        r_o_full    <= r_full;
                        r_o_dropped <= 1'b0;
                        r_o_value   <= '0;
                        r_o_present <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_PICK: begin
                    if (!r_full && col_found) begin
                        r_col  <= col_pick;
                        r_walk <= '0;
                        if (CFG_W'(col_pick) == cols_eff - CFG_W'(1))
                            r_full <= 1'b1;
                        r_state <= ST_WADDR;
                    end else if (slot_free) begin
                        r_len       <= '0;
                        r_conflict  <= '0;
                        r_out_valid <= 1'b1;
                        r_o_placed  <= 1'b0;
                        r_o_column  <= '0;
                        r_o_full    <= r_full;
                        r_o_dropped <= 1'b1;
                        r_o_value   <= '0;
                        r_o_present <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_WADDR: begin
                    r_var   <= buf_rdata[VAR_AW-1:0];
                    r_neg   <= buf_rdata[BUF_W-1];
                    r_walk  <= walk_nxt;
                    r_state <= ST_WWR;
                end
                ST_WWR: begin
                    if (r_walk < r_len) begin
                        r_state <= ST_WADDR;
                    end else begin
                        r_len         <= '0;
                        r_conflict    <= '0;
                        r_emit_placed <= 1'b1;
                        r_state       <= ST_EMIT;
                    end
                end
                ST_READ: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_o_placed  <= 1'b0;
                        r_o_column  <= '0;
                        r_o_full    <= r_full;
                        r_o_dropped <= 1'b0;
                        r_o_value   <= WORD_W'(st_val);
                        r_o_present <= WORD_W'(st_pres);
                        r_state     <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_o_placed  <= r_emit_placed;
                        r_o_column  <= r_emit_placed ? r_col : '0;
                        r_o_full    <= r_full;
                        r_o_dropped <= 1'b0;
                        r_o_value   <= '0;
                        r_o_present <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.placed       = r_o_placed;
    assign o_out.column       = r_o_column;
    assign o_out.batch_full   = r_o_full;
    assign o_out.dropped      = r_o_dropped;
    assign o_out.read_value   = r_o_value;
    assign o_out.read_present = r_o_present;

    tpbp_ram #(
        .WIDTH (ST_W),
        .DEPTH (NUM_VARS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (store_wdata),
        .i_re    (store_re),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    tpbp_ram #(
        .WIDTH (BUF_W),
        .DEPTH (MAX_LITS)
    ) u_pat_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_re    (buf_re),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

`ifndef SYNTHESIS
    a_placed_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.placed |-> o_out.column != '0 && !o_out.dropped)
        else $error("placed result with column zero or drop flag");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.placed |-> CFG_W'(o_out.column) < cols_eff)
        else $error("placed column beyond usable columns");

    a_store_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(store_we && store_re))
        else $error("store read and write in the same cycle");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_LITS))
        else $error("pattern length past buffer depth");

    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WWR && r_walk >= r_len |=> r_state == ST_EMIT && r_emit_placed)
        else $error("walk end did not lead to a placed result");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// testbench of test_pattern_bit_packer_top: directed and random requests checked against a predictor
module tb_top;
    import tpbp_pkg::*;

    typedef struct packed {
        logic        placed;
        logic [5:0]  column;
        logic        batch_full;
        logic        dropped;
        logic [63:0] rd_value;
        logic [63:0] rd_present;
    } t_packing_result;

    localparam int POOL_SIZE = 12;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    tpbp_in_if  req_ch();
    tpbp_out_if res_ch();

    test_pattern_bit_packer_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_ch),
        .o_out      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // predicted block state
    logic [63:0]      var_value   [NUM_VARS_DEF];
    logic [63:0]      var_present [NUM_VARS_DEF];
    logic [10:0]      lit_buf     [MAX_LITS_DEF];
    int               lit_count;
    logic [63:0]      conflict_cols;
    logic             batch_is_full;
    logic [CFG_W-1:0] cols_reg;

    t_packing_result awaited_results[$];
    t_packing_result head;
    int error_count;
    int items_sent;
    int burst_left;
    int stall_mode;
    int stall_left;
    int pool_lo;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous upper bound on the run, 20 ms
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic t_packing_result compute_packing_result(input t_op op,
                                                               input logic [9:0] vidx,
                                                               input logic neg,
                                                               input logic last);
        t_packing_result r;
        logic [63:0] opposite;
        logic [63:0] col_bit;
        int ncols;
        int k;
        int i;
        r = '0;
        case (op)
            OP_CLEAR: begin
                for (i = 0; i < NUM_VARS_DEF; i++) begin
                    var_value[i]   = '0;
                    var_present[i] = '0;
                end
                lit_count     = 0;
                conflict_cols = '0;
                batch_is_full = 1'b0;
            end
            OP_LIT: begin
                // literals past the buffer depth are neither checked nor written
                if (lit_count < MAX_LITS_DEF) begin
                    opposite = neg ? var_value[vidx] : ~var_value[vidx];
                    conflict_cols |= var_present[vidx] & opposite;
                    lit_buf[lit_count] = {neg, vidx};
                    lit_count++;
                end
                if (last) begin
                    if (batch_is_full) begin
                        r.dropped = 1'b1;
                    end else begin
                        ncols = int'(cols_reg);
                        if (ncols < 2)
                            ncols = 2;
                        if (ncols > NUM_COLS_DEF)
                            ncols = NUM_COLS_DEF;
                        k = 1;
                        while (k < ncols && conflict_cols[k])
                            k++;
                        if (k >= ncols) begin
                            r.dropped = 1'b1;
                        end else begin
                            col_bit = 64'd1 << k;
                            // in order, so a repeated variable keeps its later value
                            for (i = 0; i < lit_count; i++) begin
                                var_present[lit_buf[i][9:0]] |= col_bit;
                                if (lit_buf[i][10])
                                    var_value[lit_buf[i][9:0]] &= ~col_bit;
                                else
                                    var_value[lit_buf[i][9:0]] |= col_bit;
                            end
                            r.placed = 1'b1;
                            r.column = 6'(k);
                            if (k == ncols - 1)
                                batch_is_full = 1'b1;
                        end
                    end
                    lit_count     = 0;
                    conflict_cols = '0;
                end
            end
            OP_READ: begin
                r.rd_value   = var_value[vidx];
                r.rd_present = var_present[vidx];
            end
            default: begin
            end
        endcase
        r.batch_full = batch_is_full;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic logic [9:0] pick_var();
        if ($urandom_range(0, 4) == 0)
            return 10'($urandom);
        return 10'(pool_lo + $urandom_range(0, POOL_SIZE - 1));
    endfunction

    // sender: bursts of random length separated by random gaps
    task automatic issue_request(input t_op op, input logic [9:0] vidx, input logic neg,
                                 input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.var_index    <= vidx;
        req_ch.negated      <= neg;
        req_ch.last_literal <= last;
        do
            @(posedge i_clk);
        while (req_ch.ready !== 1'b1);
        awaited_results.push_back(compute_packing_result(op, vidx, neg, last));
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_columns(input logic [CFG_W-1:0] cols);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cols;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cols_reg = cols;
    endtask

    task automatic send_random_pattern();
        int len;
        int i;
        len = ($urandom_range(0, 49) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 6);
        for (i = 0; i < len; i++) begin
            // broken sequence: a clear abandons the pattern in progress
            if (i < len - 1 && $urandom_range(0, 39) == 0) begin
                issue_request(OP_CLEAR, 10'($urandom), 1'($urandom), 1'($urandom));
                return;
            end
            if ($urandom_range(0, 29) == 0)
                issue_request(OP_NONE, 10'($urandom), 1'($urandom), 1'($urandom));
            if ($urandom_range(0, 29) == 0)
                issue_request(OP_READ, pick_var(), 1'($urandom), 1'($urandom));
            issue_request(OP_LIT, pick_var(), 1'($urandom), i == len - 1);
        end
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] cols, input int n_items);
        int stop_at;
        int pick;
        write_columns(cols);
        pool_lo = $urandom_range(0, NUM_VARS_DEF - POOL_SIZE);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
                send_random_pattern();
            else if (pick < 94)
                issue_request(OP_READ, pick_var(), 1'($urandom), 1'($urandom));
            else if (pick < 97)
                issue_request(OP_NONE, 10'($urandom), 1'($urandom), 1'($urandom));
            else
                issue_request(OP_CLEAR, 10'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_reset_state();
        issue_request(OP_READ, 10'd0, 1'b0, 1'b0);
        issue_request(OP_READ, 10'd1023, 1'b1, 1'b1);
        issue_request(OP_READ, 10'h2aa, 1'b0, 1'b1);
    endtask

    task automatic test_column_choice();
        write_columns(7'd64);
        issue_request(OP_LIT, 10'd5, 1'b0, 1'b1);
        issue_request(OP_LIT, 10'd5, 1'b1, 1'b1);
        issue_request(OP_LIT, 10'd5, 1'b0, 1'b0);
        issue_request(OP_LIT, 10'd1023, 1'b1, 1'b1);
        // same variable twice in one pattern
        issue_request(OP_LIT, 10'h2aa, 1'b0, 1'b0);
        issue_request(OP_LIT, 10'h2aa, 1'b1, 1'b1);
        issue_request(OP_READ, 10'd5, 1'b0, 1'b0);
        issue_request(OP_READ, 10'd1023, 1'b0, 1'b0);
        issue_request(OP_READ, 10'h2aa, 1'b0, 1'b0);
        issue_request(OP_NONE, 10'h155, 1'b1, 1'b1);
    endtask

    task automatic test_batch_full();
        write_columns(7'd3);
        issue_request(OP_LIT, 10'd9, 1'b0, 1'b1);
        issue_request(OP_LIT, 10'd9, 1'b1, 1'b1);
        issue_request(OP_LIT, 10'd9, 1'b0, 1'b1);
        issue_request(OP_READ, 10'd9, 1'b0, 1'b0);
        issue_request(OP_LIT, 10'd9, 1'b1, 1'b0);
        issue_request(OP_CLEAR, 10'd0, 1'b0, 1'b0);
        issue_request(OP_LIT, 10'h155, 1'b0, 1'b1);
        issue_request(OP_READ, 10'd9, 1'b0, 1'b0);
    endtask

    // every usable column in conflict while the batch is not yet marked full
    task automatic test_drop_without_full();
        write_columns(7'd4);
        issue_request(OP_LIT, 10'd77, 1'b0, 1'b1);
        issue_request(OP_LIT, 10'd77, 1'b1, 1'b1);
        write_columns(7'd3);
        issue_request(OP_LIT, 10'd77, 1'b0, 1'b0);
        issue_request(OP_LIT, 10'd77, 1'b1, 1'b1);
    endtask

    task automatic test_random_packing();
        logic [CFG_W-1:0] col_plan [8];
        int p;
        col_plan = '{7'd64, 7'd2, 7'd127, 7'd0, 7'd17, 7'd65, 7'd1, 7'd40};
        col_plan[7] = 7'($urandom_range(3, 63));
        for (p = 0; p < 8; p++)
            run_random_phase(col_plan[p], 200);
    endtask

    // receiver stalls on its own changing pattern
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 200);
        end
        stall_left--;
        case (stall_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= 1'($urandom);
            2: res_ch.ready <= ($urandom_range(0, 7) != 0);
            default: res_ch.ready <= (stall_left % 5 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                $display("%0t unexpected result with no request outstanding", $time);
                error_count++;
            end else begin
                head = awaited_results.pop_front();
                check_field("placed", 64'(head.placed), 64'(res_ch.placed));
                check_field("column", 64'(head.column), 64'(res_ch.column));
                check_field("batch_full", 64'(head.batch_full), 64'(res_ch.batch_full));
                check_field("dropped", 64'(head.dropped), 64'(res_ch.dropped));
                check_field("read_value", head.rd_value, res_ch.read_value);
                check_field("read_present", head.rd_present, res_ch.read_present);
            end
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_CLEAR;
        req_ch.var_index    = '0;
        req_ch.negated      = 1'b0;
        req_ch.last_literal = 1'b0;
        res_ch.ready        = 1'b0;
        error_count = 0;
        items_sent  = 0;
        burst_left  = 0;
        stall_mode  = 0;
        stall_left  = 0;
        pool_lo     = 0;
        for (int i = 0; i < NUM_VARS_DEF; i++) begin
            var_value[i]   = '0;
            var_present[i] = '0;
        end
        lit_count     = 0;
        conflict_cols = '0;
        batch_is_full = 1'b0;
        cols_reg      = CFG_RESET;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_column_choice();
        test_batch_full();
        test_drop_without_full();
        test_random_packing();

        wait_idle();
        repeat (150) @(posedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tpbp_pkg.sv
src/tpbp_if.sv
src/tpbp_ram.sv
src/test_pattern_bit_packer_top.sv
tb/tb_top.sv
